[hw/rtl/clbm_pkg.sv]
// Shared types and constants for the CHR latch bank mapper.
// No dependencies; imported by every module of the block.
package clbm_pkg;

   localparam int unsigned ADDR_W = 16;
   localparam int unsigned DATA_W = 8;
   localparam int unsigned MIRR_W = 2;
   localparam int unsigned NUM_PRG = 3;
   localparam int unsigned NUM_CHR = 4;
   localparam int unsigned NUM_HALF = 2;

   localparam logic [ADDR_W-1:0] FETCH_MASK  = 16'h2FF0;
   localparam logic [ADDR_W-1:0] FETCH_SET   = 16'h0FD0;
   localparam logic [ADDR_W-1:0] FETCH_CLEAR = 16'h0FE0;

   localparam logic ACT_CPU_WRITE = 1'b0;
   localparam logic ACT_PPU_FETCH = 1'b1;

   localparam logic [2:0] CHR_REGION = 3'b111;

   typedef struct packed {
      logic [NUM_PRG-1:0] prg_we;
      logic [NUM_CHR-1:0] chr_we;
      logic               latch_set;
      logic               latch_clr;
      logic               latch_half;
      logic [DATA_W-1:0]  data;
   } update_cmd_type;

   typedef struct packed {
      logic [DATA_W-1:0] prg_bank_slot0;
      logic [DATA_W-1:0] prg_bank_slot1;
      logic [DATA_W-1:0] prg_bank_slot2;
      logic [DATA_W-1:0] chr_bank_low;
      logic [DATA_W-1:0] chr_bank_high;
      logic [MIRR_W-1:0] mirroring;
   } mapping_type;

endpackage

[hw/rtl/clbm_decode.sv]
// Item decoder: turns one CPU write or PPU fetch into register updates.
// Depends on clbm_pkg.
module clbm_decode import clbm_pkg::*; (
   input  logic                action,
   input  logic [ADDR_W-1:0]   address,
   input  logic [DATA_W-1:0]   write_data,
   output update_cmd_type      cmd
);

   logic              cpu_hit;
   logic              chr_hit;
   logic [1:0]        prg_slot;
   logic [1:0]        chr_slot;
   logic [ADDR_W-1:0] fetch_masked;

   assign cpu_hit      = (action == ACT_CPU_WRITE) && address[15];
   assign chr_hit      = (address[15:13] == CHR_REGION);
   assign prg_slot     = address[14:13];
   assign chr_slot     = address[11:10];
   assign fetch_masked = address & FETCH_MASK;

   always_comb begin
      cmd        = '0;
      cmd.data   = write_data;
      cmd.latch_half = address[12];
      if (cpu_hit) begin
         if (chr_hit) begin
            cmd.chr_we[chr_slot] = 1'b1;
         end else if (prg_slot != 2'd3) begin
            cmd.prg_we[prg_slot] = 1'b1;
         end
      end
      if (action == ACT_PPU_FETCH) begin
         cmd.latch_set = (fetch_masked == FETCH_SET);
         cmd.latch_clr = (fetch_masked == FETCH_CLEAR);
      end
   end

endmodule

[hw/rtl/clbm_bank_regs.sv]
// Bank and latch registers; applies one update and reports the new mapping.
// Depends on clbm_pkg.
module clbm_bank_regs import clbm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           update_en,
   input  update_cmd_type cmd,
   output mapping_type    map_in
);

   logic [DATA_W-1:0] prg_ff [NUM_PRG];
   logic [DATA_W-1:0] prg_in [NUM_PRG];
   logic [DATA_W-1:0] chr_ff [NUM_CHR];
   logic [DATA_W-1:0] chr_in [NUM_CHR];
   logic [NUM_HALF-1:0] latch_ff;
   logic [NUM_HALF-1:0] latch_in;

   always_comb begin
      for (int i = 0; i < NUM_PRG; i++) begin
         prg_in[i] = cmd.prg_we[i] ? cmd.data : prg_ff[i];
      end
      for (int i = 0; i < NUM_CHR; i++) begin
         chr_in[i] = cmd.chr_we[i] ? cmd.data : chr_ff[i];
      end
      latch_in = latch_ff;
      if (cmd.latch_set) begin
         latch_in[cmd.latch_half] = 1'b1;
      end else if (cmd.latch_clr) begin
         latch_in[cmd.latch_half] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PRG; i++) begin
            prg_ff[i] <= '0;
         end
         for (int i = 0; i < NUM_CHR; i++) begin
            chr_ff[i] <= '0;
         end
         latch_ff <= '0;
      end else if (update_en) begin
         prg_ff   <= prg_in;
         chr_ff   <= chr_in;
         latch_ff <= latch_in;
      end
   end

   always_comb begin
      map_in.prg_bank_slot0 = prg_in[0];
      map_in.prg_bank_slot1 = prg_in[1];
      map_in.prg_bank_slot2 = prg_in[2];
      map_in.chr_bank_low   = latch_in[0] ? chr_in[1] : chr_in[0];
      map_in.chr_bank_high  = latch_in[1] ? chr_in[3] : chr_in[2];
      map_in.mirroring      = map_in.chr_bank_low[DATA_W-1 -: MIRR_W];
   end

endmodule

[hw/rtl/chr_latch_bank_mapper.sv]
// CHR latch bank mapper top level: input register, decode, bank registers, result register.
// An accepted item waits in the input register; its result is registered in the result register once that is free.
// Throughput: one item per cycle while rsp_ready takes each result, set by the single update-and-result stage.
// Reset (synchronous): clears all bank registers, both latches and both valid flags.
// Depends on clbm_pkg, clbm_decode, clbm_bank_regs.
module chr_latch_bank_mapper import clbm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_action,
   input  logic [ADDR_W-1:0] req_address,
   input  logic [DATA_W-1:0] req_write_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [DATA_W-1:0] rsp_prg_bank_slot0,
   output logic [DATA_W-1:0] rsp_prg_bank_slot1,
   output logic [DATA_W-1:0] rsp_prg_bank_slot2,
   output logic [DATA_W-1:0] rsp_chr_bank_low,
   output logic [DATA_W-1:0] rsp_chr_bank_high,
   output logic [MIRR_W-1:0] rsp_mirroring
);

   logic              in_valid_ff;
   logic              in_action_ff;
   logic [ADDR_W-1:0] in_address_ff;
   logic [DATA_W-1:0] in_data_ff;
   logic              out_valid_ff;
   mapping_type       out_map_ff;
   mapping_type       map_in;
   update_cmd_type    cmd;
   logic              advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_action_ff  <= req_action;
         in_address_ff <= req_address;
         in_data_ff    <= req_write_data;
      end
   end

   clbm_decode u_decode (
      .action     (in_action_ff),
      .address    (in_address_ff),
      .write_data (in_data_ff),
      .cmd        (cmd)
   );

   clbm_bank_regs u_bank_regs (
      .clock     (clock),
      .reset     (reset),
      .update_en (advance),
      .cmd       (cmd),
      .map_in    (map_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_map_ff <= map_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_prg_bank_slot0 = out_map_ff.prg_bank_slot0;
   assign rsp_prg_bank_slot1 = out_map_ff.prg_bank_slot1;
   assign rsp_prg_bank_slot2 = out_map_ff.prg_bank_slot2;
   assign rsp_chr_bank_low   = out_map_ff.chr_bank_low;
   assign rsp_chr_bank_high  = out_map_ff.chr_bank_high;
   assign rsp_mirroring      = out_map_ff.mirroring;

endmodule

[bench/chr_latch_bank_mapper_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for chr_latch_bank_mapper: directed and random CPU writes and PPU fetches.
// Holds a bank/latch predictor in a scoreboard class; depends on clbm_pkg and the block.

import clbm_pkg::*;

class mapping_scoreboard;
   localparam logic [ADDR_W-1:0] PRG_BASE = 16'h8000;
   localparam logic [ADDR_W-1:0] CHR_BASE = 16'hE000;

   logic [DATA_W-1:0] prg_bank [NUM_PRG];
   logic [DATA_W-1:0] chr_bank [NUM_CHR];
   logic              half_latch [NUM_HALF];
   mapping_type       expected_maps [$];
   int errors;
   int checked;
   int prg_writes;
   int chr_writes;
   int latch_fetches;
   int ignored_items;

   function new();
      foreach (prg_bank[i]) prg_bank[i] = '0;
      foreach (chr_bank[i]) chr_bank[i] = '0;
      foreach (half_latch[i]) half_latch[i] = 1'b0;
      errors = 0;
      checked = 0;
      prg_writes = 0;
      chr_writes = 0;
      latch_fetches = 0;
      ignored_items = 0;
   endfunction

   function void note_item(input logic act, input logic [ADDR_W-1:0] addr,
                           input logic [DATA_W-1:0] data);
      mapping_type       m;
      logic [ADDR_W-1:0] masked;
      masked = addr & FETCH_MASK;
      if (act == ACT_CPU_WRITE) begin
         if (addr >= CHR_BASE) begin
            chr_bank[addr[11:10]] = data;
            chr_writes++;
         end else if (addr >= PRG_BASE) begin
            prg_bank[addr[14:13]] = data;
            prg_writes++;
         end else begin
            ignored_items++;
         end
      end else begin
         if (masked == FETCH_SET) begin
            half_latch[addr[12]] = 1'b1;
            latch_fetches++;
         end else if (masked == FETCH_CLEAR) begin
            half_latch[addr[12]] = 1'b0;
            latch_fetches++;
         end else begin
            ignored_items++;
         end
      end
      m.prg_bank_slot0 = prg_bank[0];
      m.prg_bank_slot1 = prg_bank[1];
      m.prg_bank_slot2 = prg_bank[2];
      m.chr_bank_low   = chr_bank[{1'b0, half_latch[0]}];
      m.chr_bank_high  = chr_bank[{1'b1, half_latch[1]}];
      m.mirroring      = m.chr_bank_low[7:6];
      expected_maps.push_back(m);
   endfunction

   task report(input string msg);
      errors++;
      if (errors <= 30) $display("MISMATCH at %0t: %s", $time, msg);
   endtask

   task check_result(input mapping_type got);
      mapping_type want;
      if (expected_maps.size() == 0) begin
         report("result arrived with no item pending");
         return;
      end
      want = expected_maps.pop_front();
      checked++;
      if (got.prg_bank_slot0 !== want.prg_bank_slot0)
         report($sformatf("prg_bank_slot0 got %h want %h", got.prg_bank_slot0,
                          want.prg_bank_slot0));
      if (got.prg_bank_slot1 !== want.prg_bank_slot1)
         report($sformatf("prg_bank_slot1 got %h want %h", got.prg_bank_slot1,
                          want.prg_bank_slot1));
      if (got.prg_bank_slot2 !== want.prg_bank_slot2)
         report($sformatf("prg_bank_slot2 got %h want %h", got.prg_bank_slot2,
                          want.prg_bank_slot2));
      if (got.chr_bank_low !== want.chr_bank_low)
         report($sformatf("chr_bank_low got %h want %h", got.chr_bank_low,
                          want.chr_bank_low));
      if (got.chr_bank_high !== want.chr_bank_high)
         report($sformatf("chr_bank_high got %h want %h", got.chr_bank_high,
                          want.chr_bank_high));
      if (got.mirroring !== want.mirroring)
         report($sformatf("mirroring got %h want %h", got.mirroring, want.mirroring));
   endtask
endclass

module chr_latch_bank_mapper_tb;
   localparam int RANDOM_ITEMS = 2000;
   localparam int CALM_ITEMS   = 300;
   localparam int BURST_ITEMS  = 30;
   localparam int LONG_HOLD    = 80;
   localparam int STUCK_LIMIT  = 4000;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic              req_action;
   logic [ADDR_W-1:0] req_address;
   logic [DATA_W-1:0] req_write_data;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [DATA_W-1:0] rsp_prg_bank_slot0;
   logic [DATA_W-1:0] rsp_prg_bank_slot1;
   logic [DATA_W-1:0] rsp_prg_bank_slot2;
   logic [DATA_W-1:0] rsp_chr_bank_low;
   logic [DATA_W-1:0] rsp_chr_bank_high;
   logic [MIRR_W-1:0] rsp_mirroring;

   mapping_scoreboard sb = new();
   bit  calm = 1'b0;
   bit  long_hold = 1'b0;
   int  stall_pct = 10;
   int  stuck_cycles = 0;

   chr_latch_bank_mapper dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_address        (req_address),
      .req_write_data     (req_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_prg_bank_slot0 (rsp_prg_bank_slot0),
      .rsp_prg_bank_slot1 (rsp_prg_bank_slot1),
      .rsp_prg_bank_slot2 (rsp_prg_bank_slot2),
      .rsp_chr_bank_low   (rsp_chr_bank_low),
      .rsp_chr_bank_high  (rsp_chr_bank_high),
      .rsp_mirroring      (rsp_mirroring)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic send_item(input logic act, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data);
      req_valid      <= 1'b1;
      req_action     <= act;
      req_address    <= addr;
      req_write_data <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic idle_req(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   function automatic int pick_pct();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 5;
         2: return 20;
         default: return 50;
      endcase
   endfunction

   always @(posedge clock) begin : monitor
      mapping_type seen;
      if (!reset) begin
         seen.prg_bank_slot0 = rsp_prg_bank_slot0;
         seen.prg_bank_slot1 = rsp_prg_bank_slot1;
         seen.prg_bank_slot2 = rsp_prg_bank_slot2;
         seen.chr_bank_low   = rsp_chr_bank_low;
         seen.chr_bank_high  = rsp_chr_bank_high;
         seen.mirroring      = rsp_mirroring;
         if (req_valid && req_ready) sb.note_item(req_action, req_address, req_write_data);
         if (rsp_valid && rsp_ready) sb.check_result(seen);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stuck_cycles = 0;
         end else begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
               $display("no progress for %0d cycles", STUCK_LIMIT);
               $display("chr_latch_bank_mapper test failed");
               $finish;
            end
         end
      end
   end

   initial begin
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold = 1'b0;
         end else if (!calm && $urandom_range(1, 100) <= stall_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      int                gap_pct;
      int                kind;
      logic              act;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
      gap_pct = 0;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_action     <= ACT_CPU_WRITE;
      req_address    <= '0;
      req_write_data <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_item(ACT_CPU_WRITE, 16'h0000, 8'hFF);
      send_item(ACT_CPU_WRITE, 16'h7FFF, 8'hFF);
      send_item(ACT_CPU_WRITE, 16'h8000, 8'hFF);
      send_item(ACT_CPU_WRITE, 16'hA000, 8'h80);
      send_item(ACT_CPU_WRITE, 16'hDFFF, 8'h01);
      send_item(ACT_CPU_WRITE, 16'hE000, 8'h3F);
      send_item(ACT_CPU_WRITE, 16'hE7FF, 8'h7F);
      send_item(ACT_CPU_WRITE, 16'hEBFF, 8'h81);
      send_item(ACT_CPU_WRITE, 16'hFFFF, 8'hFE);
      send_item(ACT_PPU_FETCH, 16'h0FD0, 8'hFF);
      send_item(ACT_PPU_FETCH, 16'h1FDF, 8'h00);
      send_item(ACT_PPU_FETCH, 16'h2FD0, 8'hFF);
      send_item(ACT_PPU_FETCH, 16'hFFFF, 8'hFF);
      send_item(ACT_PPU_FETCH, 16'h0000, 8'h00);
      send_item(ACT_PPU_FETCH, 16'hCFE5, 8'hAA);
      send_item(ACT_CPU_WRITE, 16'hE400, 8'hC0);
      send_item(ACT_PPU_FETCH, 16'h0FD8, 8'h55);
      send_item(ACT_CPU_WRITE, 16'hE000, 8'h80);
      send_item(ACT_PPU_FETCH, 16'h1FE0, 8'hFF);
      send_item(ACT_PPU_FETCH, 16'h0FEF, 8'h00);
      send_item(ACT_CPU_WRITE, 16'h9FFF, 8'h55);
      send_item(ACT_CPU_WRITE, 16'hC000, 8'hAA);
      send_item(ACT_PPU_FETCH, 16'h8000, 8'hFF);
      send_item(ACT_PPU_FETCH, 16'hDFD0, 8'h00);

      long_hold = 1'b1;
      for (int i = 0; i < BURST_ITEMS; i++)
         send_item(ACT_CPU_WRITE, ADDR_W'($urandom_range(16'h8000, 16'hFFFF)),
                   DATA_W'($urandom_range(0, 255)));

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 200 == 0) begin
            gap_pct   = pick_pct();
            stall_pct = pick_pct();
         end
         if (i == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
         if (!calm && $urandom_range(1, 100) <= gap_pct) idle_req($urandom_range(1, 19));
         kind = $urandom_range(0, 99);
         act  = ACT_CPU_WRITE;
         addr = ADDR_W'($urandom_range(0, 16'hFFFF));
         data = DATA_W'($urandom_range(0, 255));
         if (kind < 25) begin
            addr = ADDR_W'($urandom_range(16'h8000, 16'hDFFF));
         end else if (kind < 50) begin
            addr = ADDR_W'($urandom_range(16'hE000, 16'hFFFF));
         end else if (kind < 85) begin
            act       = ACT_PPU_FETCH;
            addr[13]  = 1'b0;
            addr[11:4] = $urandom_range(0, 1) ? FETCH_SET[11:4] : FETCH_CLEAR[11:4];
         end else if (kind < 90) begin
            act       = ACT_PPU_FETCH;
            addr[13]  = 1'b1;
            addr[11:4] = $urandom_range(0, 1) ? FETCH_SET[11:4] : FETCH_CLEAR[11:4];
         end else begin
            act = $urandom_range(0, 1) ? ACT_PPU_FETCH : ACT_CPU_WRITE;
         end
         send_item(act, addr, data);
      end

      req_valid <= 1'b0;
      while (sb.expected_maps.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("checked %0d results: %0d PRG writes, %0d CHR writes, %0d latch fetches,",
               sb.checked, sb.prg_writes, sb.chr_writes, sb.latch_fetches);
      $display("%0d items that left the mapping alone, %0d mismatches",
               sb.ignored_items, sb.errors);
      if (sb.errors == 0) begin
         $display("chr_latch_bank_mapper test passed");
      end else begin
         $display("chr_latch_bank_mapper test failed");
      end
      $finish;
   end
endmodule

[filelist.f]
hw/rtl/clbm_pkg.sv
hw/rtl/clbm_decode.sv
hw/rtl/clbm_bank_regs.sv
hw/rtl/chr_latch_bank_mapper.sv
bench/chr_latch_bank_mapper_tb.sv
